@@ src/assert_macros.svh @@
// assert_macros.svh: concurrent assertion helpers for the timer event queue.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising clk edge, off while in reset.
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

@@ src/teq_pkg.sv @@
// teq_pkg.sv: types and constants of the timer event queue.
// No dependencies; used by every module of the block.
package teq_pkg;

    localparam int CAPACITY  = 64;
    localparam int ID_BITS   = 32;
    localparam int TIME_BITS = 48;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = 7;

    localparam logic [1:0] ACT_SCHEDULE = 2'd0;
    localparam logic [1:0] ACT_CANCEL   = 2'd1;
    localparam logic [1:0] ACT_ADVANCE  = 2'd2;
    localparam logic [1:0] ACT_NOP      = 2'd3;

    typedef struct packed {
        logic [1:0]           action;
        logic [ID_BITS-1:0]   ev_id;
        logic [TIME_BITS-1:0] event_time;
    } cmd_t;

    typedef struct packed {
        logic                 fired_valid;
        logic [ID_BITS-1:0]   fired_id;
        logic [TIME_BITS-1:0] fired_time;
        logic                 last;
        logic                 found;
        logic                 status;
        logic [CNT_W-1:0]     pending_count;
        logic [TIME_BITS-1:0] next_time;
        logic                 queue_empty;
        logic [CNT_W-1:0]     fired_count;
    } res_t;

    typedef enum logic [1:0] {
        SCAN_MATCH,
        SCAN_SUM_ALL,
        SCAN_SUM_DUE,
        SCAN_PICK
    } scan_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_WRITE,
        ST_SUM,
        ST_CHECK,
        ST_PICK,
        ST_FIRE,
        ST_PLAIN
    } state_t;

    typedef struct packed {
        logic       load_op;
        logic       clr_scan;
        logic       step;
        scan_mode_t mode;
        logic       write_entry;
        logic       load_plain;
        logic       load_fire;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       scan_last;
        logic [1:0] action;
        logic       due_zero;
        logic       last_fire;
        logic       res_free;
    } ctrl_stat_t;

endpackage

@@ src/teq_ctrl.sv @@
// teq_ctrl.sv: sequencing state machine of the timer event queue.
// Depends on teq_pkg.
module teq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  teq_pkg::ctrl_stat_t stat,
    output teq_pkg::ctrl_cmd_t  ctl
);

    teq_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= teq_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            teq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = teq_pkg::ST_MATCH;
            end
            teq_pkg::ST_MATCH:
            begin
                // advance and unused code skip the id match
                if (stat.action == teq_pkg::ACT_ADVANCE || stat.action == teq_pkg::ACT_NOP)
                    state_next = teq_pkg::ST_SUM;
                else if (stat.scan_last)
                    state_next = teq_pkg::ST_WRITE;
            end
            teq_pkg::ST_WRITE: state_next = teq_pkg::ST_SUM;
            teq_pkg::ST_SUM:
            begin
                if (stat.scan_last)
                    state_next = (stat.action == teq_pkg::ACT_ADVANCE) ?
                                 teq_pkg::ST_CHECK : teq_pkg::ST_PLAIN;
            end
            teq_pkg::ST_CHECK:
                state_next = stat.due_zero ? teq_pkg::ST_PLAIN : teq_pkg::ST_PICK;
            teq_pkg::ST_PICK:
            begin
                if (stat.scan_last)
                    state_next = teq_pkg::ST_FIRE;
            end
            teq_pkg::ST_FIRE:
            begin
                if (stat.res_free)
                    state_next = stat.last_fire ? teq_pkg::ST_IDLE : teq_pkg::ST_PICK;
            end
            teq_pkg::ST_PLAIN:
            begin
                if (stat.res_free)
                    state_next = teq_pkg::ST_IDLE;
            end
            default: state_next = teq_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        ctl       = '0;
        ctl.mode  = teq_pkg::SCAN_MATCH;
        unique case (state_reg)
            teq_pkg::ST_IDLE:
            begin
                cmd_ready    = 1'b1;
                ctl.load_op  = cmd_valid;
                ctl.clr_scan = 1'b1;
            end
            teq_pkg::ST_MATCH:
            begin
                if (stat.action == teq_pkg::ACT_ADVANCE || stat.action == teq_pkg::ACT_NOP)
                    ctl.clr_scan = 1'b1;
                else
                    ctl.step = 1'b1;
            end
            teq_pkg::ST_WRITE:
            begin
                ctl.write_entry = 1'b1;
                ctl.clr_scan    = 1'b1;
            end
            teq_pkg::ST_SUM:
            begin
                ctl.step = 1'b1;
                ctl.mode = (stat.action == teq_pkg::ACT_ADVANCE) ?
                           teq_pkg::SCAN_SUM_DUE : teq_pkg::SCAN_SUM_ALL;
            end
            teq_pkg::ST_CHECK: ctl.clr_scan = 1'b1;
            teq_pkg::ST_PICK:
            begin
                ctl.step = 1'b1;
                ctl.mode = teq_pkg::SCAN_PICK;
            end
            teq_pkg::ST_FIRE:
            begin
                ctl.load_fire = stat.res_free;
                ctl.clr_scan  = stat.res_free;
            end
            teq_pkg::ST_PLAIN: ctl.load_plain = stat.res_free;
            default: ;
        endcase
    end

endmodule

@@ src/teq_datapath.sv @@
// teq_datapath.sv: entry store, scan accumulators and result register.
// Depends on teq_pkg.
module teq_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  teq_pkg::cmd_t       cmd,
    input  teq_pkg::ctrl_cmd_t  ctl,
    output teq_pkg::ctrl_stat_t stat,
    output logic                res_valid,
    input  logic                res_ready,
    output teq_pkg::res_t       res
);

    localparam int CAP = teq_pkg::CAPACITY;
    localparam int IW  = teq_pkg::IDX_W;
    localparam int CW  = teq_pkg::CNT_W;
    localparam int IB  = teq_pkg::ID_BITS;
    localparam int TB  = teq_pkg::TIME_BITS;

    // Entry store: valid bits in flops, id and time in memories
    logic [CAP-1:0] valid_reg;
    logic [IB-1:0]  id_mem   [CAP];
    logic [TB-1:0]  time_mem [CAP];

    teq_pkg::cmd_t  op_reg;
    logic [CW-1:0]  cnt_reg;
    logic           rd_valid_reg;
    logic [IB-1:0]  rd_id_reg;
    logic [TB-1:0]  rd_time_reg;
    logic [IW-1:0]  rd_idx_reg;

    logic           match_hit_reg, free_hit_reg;
    logic [IW-1:0]  match_idx_reg, free_idx_reg;
    logic [CW-1:0]  rem_cnt_reg, due_cnt_reg, fired_reg;
    logic           min_any_reg;
    logic [TB-1:0]  min_time_reg;
    logic           pick_hit_reg;
    logic [IW-1:0]  pick_idx_reg;
    logic [IB-1:0]  pick_id_reg;
    logic [TB-1:0]  pick_time_reg;
    logic           found_reg, status_reg;
    logic           res_valid_reg;
    teq_pkg::res_t  res_reg;

    logic           issue, proc;
    logic           sel_rem, sel_due, sel_pick;
    logic [CW-1:0]  fired_inc;

    assign issue     = ctl.step && (cnt_reg < CW'(CAP));
    assign proc      = ctl.step && (cnt_reg != '0);
    assign fired_inc = fired_reg + CW'(1);

    // Scan qualifiers on the entry that was read last cycle
    always_comb
    begin
        sel_rem  = rd_valid_reg && ((ctl.mode == teq_pkg::SCAN_SUM_ALL) ||
                   (rd_time_reg > op_reg.event_time));
        sel_due  = rd_valid_reg && (ctl.mode == teq_pkg::SCAN_SUM_DUE) &&
                   (rd_time_reg <= op_reg.event_time);
        sel_pick = rd_valid_reg && (rd_time_reg <= op_reg.event_time) &&
                   (!pick_hit_reg || (rd_time_reg < pick_time_reg) ||
                    ((rd_time_reg == pick_time_reg) && (rd_id_reg < pick_id_reg)));
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.write_entry && op_reg.action == teq_pkg::ACT_SCHEDULE)
        begin
            if (match_hit_reg)
                time_mem[match_idx_reg] <= op_reg.event_time;
            else if (free_hit_reg)
            begin
                id_mem[free_idx_reg]   <= op_reg.ev_id;
                time_mem[free_idx_reg] <= op_reg.event_time;
            end
        end
        if (issue)
        begin
            rd_id_reg   <= id_mem[cnt_reg[IW-1:0]];
            rd_time_reg <= time_mem[cnt_reg[IW-1:0]];
        end
    end

    // Valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (ctl.write_entry)
        begin
            if (op_reg.action == teq_pkg::ACT_SCHEDULE && !match_hit_reg && free_hit_reg)
                valid_reg[free_idx_reg] <= 1'b1;
            else if (op_reg.action == teq_pkg::ACT_CANCEL && match_hit_reg)
                valid_reg[match_idx_reg] <= 1'b0;
        end
        else if (ctl.load_fire)
            valid_reg[pick_idx_reg] <= 1'b0;
    end

    // Scan counter and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            match_hit_reg <= 1'b0;
            free_hit_reg  <= 1'b0;
            rem_cnt_reg   <= '0;
            due_cnt_reg   <= '0;
            min_any_reg   <= 1'b0;
            pick_hit_reg  <= 1'b0;
            fired_reg     <= '0;
            found_reg     <= 1'b0;
            status_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.load_op)
            begin
                match_hit_reg <= 1'b0;
                free_hit_reg  <= 1'b0;
                rem_cnt_reg   <= '0;
                due_cnt_reg   <= '0;
                min_any_reg   <= 1'b0;
                fired_reg     <= '0;
            end
            if (ctl.clr_scan)
            begin
                cnt_reg      <= '0;
                pick_hit_reg <= 1'b0;
            end
            else if (issue)
                cnt_reg <= cnt_reg + CW'(1);
            if (issue)
            begin
                rd_valid_reg <= valid_reg[cnt_reg[IW-1:0]];
                rd_idx_reg   <= cnt_reg[IW-1:0];
            end
            if (proc)
            begin
                unique case (ctl.mode) inside
                    teq_pkg::SCAN_MATCH:
                    begin
                        if (rd_valid_reg && !match_hit_reg && rd_id_reg == op_reg.ev_id)
                        begin
                            match_hit_reg <= 1'b1;
                            match_idx_reg <= rd_idx_reg;
                        end
                        if (!rd_valid_reg && !free_hit_reg)
                        begin
                            free_hit_reg <= 1'b1;
                            free_idx_reg <= rd_idx_reg;
                        end
                    end
                    teq_pkg::SCAN_SUM_ALL, teq_pkg::SCAN_SUM_DUE:
                    begin
                        if (sel_rem)
                        begin
                            rem_cnt_reg <= rem_cnt_reg + CW'(1);
                            if (!min_any_reg || rd_time_reg < min_time_reg)
                            begin
                                min_any_reg  <= 1'b1;
                                min_time_reg <= rd_time_reg;
                            end
                        end
                        if (sel_due)
                            due_cnt_reg <= due_cnt_reg + CW'(1);
                    end
                    teq_pkg::SCAN_PICK:
                    begin
                        if (sel_pick)
                        begin
                            pick_hit_reg  <= 1'b1;
                            pick_idx_reg  <= rd_idx_reg;
                            pick_id_reg   <= rd_id_reg;
                            pick_time_reg <= rd_time_reg;
                        end
                    end
                    default: ;
                endcase
            end
            if (ctl.write_entry)
            begin
                found_reg  <= match_hit_reg;
                status_reg <= (op_reg.action == teq_pkg::ACT_SCHEDULE) &&
                              !match_hit_reg && !free_hit_reg;
            end
            else if (ctl.load_op)
            begin
                found_reg  <= 1'b0;
                status_reg <= 1'b0;
            end
            if (ctl.load_fire)
                fired_reg <= fired_inc;
        end
    end

    // Input transaction capture
    always_ff @(posedge clk)
    begin
        if (ctl.load_op)
            op_reg <= cmd;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (ctl.load_plain || ctl.load_fire)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_plain || ctl.load_fire)
        begin
            res_reg.fired_valid   <= ctl.load_fire;
            res_reg.fired_id      <= ctl.load_fire ? pick_id_reg : '0;
            res_reg.fired_time    <= ctl.load_fire ? pick_time_reg : '0;
            res_reg.last          <= ctl.load_plain || (fired_inc == due_cnt_reg);
            res_reg.found         <= found_reg;
            res_reg.status        <= status_reg;
            res_reg.pending_count <= rem_cnt_reg;
            res_reg.next_time     <= min_any_reg ? min_time_reg : '0;
            res_reg.queue_empty   <= (rem_cnt_reg == '0);
            res_reg.fired_count   <= ctl.load_fire ? fired_inc : '0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Status to the controller
    assign stat.scan_last = ctl.step && (cnt_reg == CW'(CAP));
    assign stat.action    = op_reg.action;
    assign stat.due_zero  = (due_cnt_reg == '0);
    assign stat.last_fire = (fired_inc == due_cnt_reg);
    assign stat.res_free  = !res_valid_reg || res_ready;

endmodule

@@ src/timer_event_queue_unit.sv @@
// timer_event_queue_unit.sv: top level of the timer event queue.
// Depends on teq_pkg, teq_ctrl, teq_datapath and assert_macros.svh.
//
// Usage: commands enter on cmd (valid/ready); results leave on res (valid/ready).
// One transaction is taken at a time: cmd_ready is high only while the
// sequencer is idle. Each command walks the 64-entry store one entry per
// cycle through a single registered memory read port.
// Schedule / cancel: id match scan, store write, summary scan, then one result.
// Advance: summary scan counting due events, then one selection scan per
// fired event, each giving one result; the last result carries last=1.
// With nothing due a single empty result follows the summary.
// A result waits in the output register while the receiver stalls; the next
// selection scan runs meanwhile and holds until the register frees.
// Reset clears all valid bits at once, so the store is empty right away.
`include "assert_macros.svh"

module timer_event_queue_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  teq_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output teq_pkg::res_t res
);

    teq_pkg::ctrl_cmd_t  ctl;
    teq_pkg::ctrl_stat_t stat;

    teq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    teq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .stat      (stat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Assertions
    `ASSERT_IMPL(a_count_range, res_valid, res.pending_count <= 7'(teq_pkg::CAPACITY), "pending count out of range")
    `ASSERT_IMPL(a_empty_flag, res_valid, res.queue_empty == (res.pending_count == '0), "empty flag mismatch")
    `ASSERT_IMPL(a_fire_count, res_valid && res.fired_valid, res.fired_count != '0, "fired event without count")
    `ASSERT_CLK(a_load_excl, !(ctl.load_fire && ctl.load_plain), "two result loads at once")

endmodule
